/* design/sorted_deadline_timer_queue_top_assert.svh */
// Assertion macros for the sorted deadline timer queue.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_TOP_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SDTQ_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdtq: assertion failed");

// Invariant checked on every clock edge outside reset.
`define SDTQ_ASSERT_ALWAYS(name, clk, rst, cond) \
  `SDTQ_ASSERT_IMP(name, clk, rst, 1'b1, cond)

`endif

/* design/sdtq_pkg.sv */
// Shared types, constants and the reload function of the sorted deadline timer queue.
// No dependencies.
`default_nettype none

package sdtq_pkg;

  localparam int ID_W     = 4;
  localparam int TIME_W   = 63;
  localparam int RELOAD_W = 16;

  localparam logic [RELOAD_W-1:0] RELOAD_MIN = 16'd2;
  localparam logic [RELOAD_W-1:0] RELOAD_MAX = 16'd65534;

  localparam logic ACT_ARM  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic KIND_FIRE   = 1'b0;
  localparam logic KIND_RELOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  // One slot of the ordered list: timer id and its deadline.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] dl;
  } entry_t;

  typedef struct packed {
    logic                kind;
    logic [ID_W-1:0]     fired_id;
    logic [TIME_W-1:0]   expired_at;
    logic [RELOAD_W-1:0] reload;
    logic                last;
  } result_t;

  // Countdown reload: deadline minus now, clamped to RELOAD_MIN..RELOAD_MAX.
  function automatic logic [RELOAD_W-1:0] reload_of(input logic [TIME_W-1:0] dl,
                                                    input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] diff;
    diff = dl - now;
    if (dl <= now) begin
      return RELOAD_MIN;
    end else if (diff > TIME_W'(RELOAD_MAX)) begin
      return RELOAD_MAX;
    end else if (diff < TIME_W'(RELOAD_MIN)) begin
      return RELOAD_MIN;
    end else begin
      return diff[RELOAD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* design/sdtq_if.sv */
// Valid/ready channel interfaces for the input items and the results.
// Depends on sdtq_pkg for field widths.
`default_nettype none

interface sdtq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [sdtq_pkg::ID_W-1:0]         timer_id;
  logic [sdtq_pkg::TIME_W-1:0]       deadline;
  logic [sdtq_pkg::TIME_W-1:0]       now;

  modport source (output valid, action, timer_id, deadline, now, input ready);
  modport sink   (input valid, action, timer_id, deadline, now, output ready);
endinterface

interface sdtq_out_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [sdtq_pkg::ID_W-1:0]         fired_id;
  logic [sdtq_pkg::TIME_W-1:0]       expired_at;
  logic [sdtq_pkg::RELOAD_W-1:0]     reload;
  logic                              last;

  modport source (output valid, kind, fired_id, expired_at, reload, last, input ready);
  modport sink   (input valid, kind, fired_id, expired_at, reload, last, output ready);
endinterface

`default_nettype wire

/* design/sorted_deadline_timer_queue_top.sv */
// Sorted deadline timer queue: up to NUM_TIMERS one-shot timers kept in deadline
// order in a single entry memory. An arm beat removes the timer if it is queued and
// re-inserts it behind every timer with an equal or earlier deadline; if it lands
// at the head, one reload beat follows. A tick beat fires, in order, every timer
// whose deadline is at or before now (one fire beat each), then gives a reload beat
// for the new head if the queue is not empty. Reload is deadline minus now, clamped
// to 2..65534. The list is walked at one memory read per cycle while the result
// channel has room, and no new beat is taken until the whole pass is done; an arm
// with an id at or beyond NUM_TIMERS and a tick on an empty queue start no pass.
// Each pass reads slot r while writing the compacted or shifted list at a slot no
// higher than r, so no read ever meets a pending write. Only slots below the count
// are read, so the memory needs no clearing after reset. Results wait in an output
// register, which frees the block for the next beat.
// Depends on sdtq_pkg, sdtq_if, sdtq_entry_ram, sdtq_out_stage and sdtq_seq.
`default_nettype none

module sorted_deadline_timer_queue_top #(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sdtq_in_if.sink    in_ch,
  sdtq_out_if.source out_ch
);

  localparam int IDX_W = $clog2(NUM_TIMERS);

  // entry memory ports
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  sdtq_pkg::entry_t   rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  sdtq_pkg::entry_t   wr_data;

  // sequencer to output register
  logic               res_valid;
  sdtq_pkg::result_t  res;
  logic               res_free;

  // ordered list of {id, deadline}, slot 0 is the head
  sdtq_entry_ram #(
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // arm / tick passes over the list
  sdtq_seq #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free)
  );

  // result beat register
  sdtq_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

/* design/sdtq_entry_ram.sv */
// Ordered-list memory: one write port, one read port with registered data.
// Depends on sdtq_pkg for the entry type.
`default_nettype none

module sdtq_entry_ram #(
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output sdtq_pkg::entry_t      rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire sdtq_pkg::entry_t wr_data
);

  sdtq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/sdtq_out_stage.sv */
// Result output register that decouples the sequencer from the result channel.
// Depends on sdtq_pkg and sdtq_out_if.
`default_nettype none

module sdtq_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_valid,
  input  wire sdtq_pkg::result_t res,
  output logic                   res_free,
  sdtq_out_if.source             out_ch
);

  logic              valid;
  sdtq_pkg::result_t data;

  assign res_free = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_valid) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      data <= res;
    end
  end

  assign out_ch.valid      = valid;
  assign out_ch.kind       = data.kind;
  assign out_ch.fired_id   = data.fired_id;
  assign out_ch.expired_at = data.expired_at;
  assign out_ch.reload     = data.reload;
  assign out_ch.last       = data.last;

endmodule

`default_nettype wire

/* design/sdtq_seq.sv */
// Sequencer: streams the ordered list through read-modify-write passes for arm and tick.
// Depends on sdtq_pkg, sdtq_in_if and the assertion macro header.
`default_nettype none
`include "sorted_deadline_timer_queue_top_assert.svh"

module sdtq_seq #(
  parameter int  NUM_TIMERS = 16,
  localparam int IDX_W      = $clog2(NUM_TIMERS),
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  sdtq_in_if.sink                in_ch,
  output logic                   rd_en,
  output logic [IDX_W-1:0]       rd_addr,
  input  wire sdtq_pkg::entry_t  rd_data,
  output logic                   wr_en,
  output logic [IDX_W-1:0]       wr_addr,
  output sdtq_pkg::entry_t       wr_data,
  output logic                   res_valid,
  output sdtq_pkg::result_t      res,
  input  wire logic              res_free
);

  sdtq_pkg::state_t state, state_next;

  logic                          act, act_next;
  logic [sdtq_pkg::ID_W-1:0]     aid, aid_next;
  logic [sdtq_pkg::TIME_W-1:0]   adl, adl_next;
  logic [sdtq_pkg::TIME_W-1:0]   anow, anow_next;
  logic [CNT_W-1:0]              count, count_next;
  logic [CNT_W-1:0]              r, r_next;
  logic [CNT_W-1:0]              w, w_next;
  logic                          flag, flag_next;  // tick: head found; arm: new entry placed
  logic                          head, head_next;
  sdtq_pkg::entry_t              carry, carry_next;

  logic                          accept;
  logic                          id_ok;
  logic                          start_scan;
  logic [CNT_W-1:0]              r_inc;
  logic                          last_ent;
  logic                          skip;
  logic                          fire;
  logic                          ins_now;
  logic                          need_out;
  logic                          consume;
  logic                          fin_head;
  logic                          fin_go;
  sdtq_pkg::entry_t              new_ent;
  logic [sdtq_pkg::TIME_W-1:0]   rel_dl;
  logic [sdtq_pkg::RELOAD_W-1:0] rel_val;

  assign accept     = in_ch.valid && in_ch.ready;
  assign id_ok      = 32'(in_ch.timer_id) < 32'(NUM_TIMERS);
  assign start_scan = (count != '0) && ((in_ch.action == sdtq_pkg::ACT_TICK) || id_ok);
  assign r_inc      = r + CNT_W'(1);
  assign last_ent   = (r_inc == count);
  assign skip       = (rd_data.id == aid);
  assign fire       = !flag && (rd_data.dl <= anow);
  assign ins_now    = !skip && !flag && (rd_data.dl > adl);
  assign need_out   = (act == sdtq_pkg::ACT_TICK) && !flag;
  assign fin_head   = flag ? head : (w == '0);
  assign new_ent    = '{id: aid, dl: adl};
  assign rel_dl     = (state == sdtq_pkg::ST_FIN) ? adl : rd_data.dl;
  assign rel_val    = sdtq_pkg::reload_of(rel_dl, anow);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sdtq_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_ch.action == sdtq_pkg::ACT_ARM && id_ok && count == '0) begin
            state_next = sdtq_pkg::ST_FIN;
          end else if (start_scan) begin
            state_next = sdtq_pkg::ST_SCAN;
          end
        end
      end
      sdtq_pkg::ST_SCAN: begin
        if (consume && last_ent) begin
          state_next = (act == sdtq_pkg::ACT_ARM) ? sdtq_pkg::ST_FIN : sdtq_pkg::ST_IDLE;
        end
      end
      sdtq_pkg::ST_FIN: begin
        if (fin_go) begin
          state_next = sdtq_pkg::ST_IDLE;
        end
      end
      default: state_next = sdtq_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    in_ch.ready = (state == sdtq_pkg::ST_IDLE);
    rd_en       = 1'b0;
    rd_addr     = r_inc[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = w[IDX_W-1:0];
    wr_data     = rd_data;
    res_valid   = 1'b0;
    res         = '{kind: sdtq_pkg::KIND_RELOAD, fired_id: '0, expired_at: '0,
                    reload: rel_val, last: 1'b1};
    consume     = 1'b0;
    fin_go      = 1'b0;
    case (state)
      sdtq_pkg::ST_IDLE: begin
        if (accept && start_scan) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      sdtq_pkg::ST_SCAN: begin
        consume = !(need_out && !res_free);
        rd_en   = consume && !last_ent;
        if (act == sdtq_pkg::ACT_TICK) begin
          res_valid = consume && !flag;
          wr_en     = consume && !fire;
          wr_data   = rd_data;
          if (fire) begin
            res = '{kind: sdtq_pkg::KIND_FIRE, fired_id: rd_data.id,
                    expired_at: rd_data.dl, reload: '0, last: last_ent};
          end
        end else begin
          wr_en   = consume && !skip;
          wr_data = ins_now ? new_ent : (flag ? carry : rd_data);
        end
      end
      sdtq_pkg::ST_FIN: begin
        fin_go    = !fin_head || res_free;
        wr_en     = fin_go;
        wr_data   = flag ? carry : new_ent;
        res_valid = fin_head && res_free;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    act_next   = act;
    aid_next   = aid;
    adl_next   = adl;
    anow_next  = anow;
    count_next = count;
    r_next     = r;
    w_next     = w;
    flag_next  = flag;
    head_next  = head;
    carry_next = carry;
    case (state)
      sdtq_pkg::ST_IDLE: begin
        if (accept) begin
          act_next  = in_ch.action;
          aid_next  = in_ch.timer_id;
          adl_next  = in_ch.deadline;
          anow_next = in_ch.now;
          r_next    = '0;
          w_next    = '0;
          flag_next = 1'b0;
          head_next = 1'b0;
        end
      end
      sdtq_pkg::ST_SCAN: begin
        if (consume) begin
          r_next = r_inc;
          if (act == sdtq_pkg::ACT_TICK) begin
            if (!fire) begin
              w_next    = w + CNT_W'(1);
              flag_next = 1'b1;
            end
            if (last_ent) begin
              count_next = w_next;
            end
          end else if (!skip) begin
            w_next = w + CNT_W'(1);
            if (ins_now) begin
              flag_next  = 1'b1;
              head_next  = (w == '0);
              carry_next = rd_data;
            end else if (flag) begin
              carry_next = rd_data;
            end
          end
        end
      end
      sdtq_pkg::ST_FIN: begin
        if (fin_go) begin
          count_next = w + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdtq_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    act   <= act_next;
    aid   <= aid_next;
    adl   <= adl_next;
    anow  <= anow_next;
    r     <= r_next;
    w     <= w_next;
    flag  <= flag_next;
    head  <= head_next;
    carry <= carry_next;
  end

  // writes trail reads, so one pass never reads a slot it has already overwritten
  `SDTQ_ASSERT_IMP(a_wr_behind_rd, clk, rst, wr_en && rd_en, wr_addr < rd_addr)
  `SDTQ_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(NUM_TIMERS))
  `SDTQ_ASSERT_IMP(a_res_room, clk, rst, res_valid, res_free)
  `SDTQ_ASSERT_IMP(a_reload_range, clk, rst, res_valid && res.kind == sdtq_pkg::KIND_RELOAD, res.reload >= sdtq_pkg::RELOAD_MIN && res.reload <= sdtq_pkg::RELOAD_MAX)
  `SDTQ_ASSERT_IMP(a_fin_is_arm, clk, rst, state == sdtq_pkg::ST_FIN, act == sdtq_pkg::ACT_ARM)

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the sorted deadline timer queue: drives arm and tick beats,
// predicts the fire and reload beats in-line and compares every result field by field.
// Depends on sdtq_pkg, sdtq_if and sorted_deadline_timer_queue_top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdtq_pkg::*;

  localparam int NTIMERS        = 16;
  localparam int MAX_FIRES      = 16;   // the expiry walk stops after this many fires
  localparam int IDLE_PCT       = 15;   // chance of an idle gap on either side
  localparam int HOLD_CYCLES    = 200;  // long receiver hold-off in the backpressure test
  localparam int DRAIN_CYCLES   = 40;   // trailing quiet window at the end of the run
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no beat on either channel
  localparam int RANDOM_BEATS   = 120;
  localparam int MAX_REPORTS    = 10;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic clk = 1'b0;
  logic rst;

  sdtq_in_if  in_if ();
  sdtq_out_if out_if ();

  sorted_deadline_timer_queue_top #(
    .NUM_TIMERS(NTIMERS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Timer queue predictor: ids in deadline order, per-timer deadline and armed
  // flag. Expected beats are queued in the order the block must send them.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]   q_order    [NTIMERS];
  logic [TIME_W-1:0] q_deadline [NTIMERS];
  bit                q_armed    [NTIMERS];
  int                q_count = 0;
  result_t           pending_events [$];

  int errors      = 0;
  int arm_beats   = 0;
  int tick_beats  = 0;
  int fire_seen   = 0;
  int reload_seen = 0;
  int beats_sent  = 0;
  int quiet_cycles = 0;

  bit no_idle      = 1'b0;  // suppresses random idling on both sides
  bit hold_request = 1'b0;  // asks the receiver for one long hold-off
  logic [TIME_W-1:0] sim_now;  // running time base for well-formed sequences

  // Countdown value: time left to the deadline, clamped to the hardware range.
  function automatic logic [RELOAD_W-1:0] countdown_for(logic [TIME_W-1:0] dl,
                                                        logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] gap;
    if (dl <= now) return RELOAD_MIN;
    gap = dl - now;
    if (gap > TIME_W'(RELOAD_MAX)) return RELOAD_MAX;
    if (gap < TIME_W'(RELOAD_MIN)) return RELOAD_MIN;
    return gap[RELOAD_W-1:0];
  endfunction

  function automatic result_t make_event(logic kind, logic [ID_W-1:0] id,
                                         logic [TIME_W-1:0] at, logic [RELOAD_W-1:0] rl);
    result_t ev;
    ev.kind       = kind;
    ev.fired_id   = id;
    ev.expired_at = at;
    ev.reload     = rl;
    ev.last       = 1'b0;
    return ev;
  endfunction

  // Close the gap left by the timer at slot pos.
  function automatic void unlink_slot(int pos);
    int i;
    for (i = pos; i + 1 < q_count; i++) q_order[i] = q_order[i + 1];
    q_count--;
  endfunction

  function automatic void predict_timer_events(logic act, logic [ID_W-1:0] id,
                                               logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now);
    result_t         batch [$];
    result_t         ev;
    int              pos;
    int              i;
    int              fired;
    logic [ID_W-1:0] head;
    if (act == ACT_ARM) begin
      arm_beats++;
      if (int'(id) >= NTIMERS) return;
      // re-arm: pull the timer out of its old slot first
      if (q_armed[id]) begin
        pos = 0;
        while (pos < q_count && q_order[pos] != id) pos++;
        if (pos < q_count) unlink_slot(pos);
        q_armed[id] = 1'b0;
      end
      if (q_count >= NTIMERS) return;
      // behind every timer with an equal or earlier deadline
      pos = 0;
      while (pos < q_count && q_deadline[q_order[pos]] <= dl) pos++;
      for (i = q_count; i > pos; i--) q_order[i] = q_order[i - 1];
      q_order[pos]   = id;
      q_count++;
      q_deadline[id] = dl;
      q_armed[id]    = 1'b1;
      if (pos == 0) batch.push_back(make_event(KIND_RELOAD, '0, '0, countdown_for(dl, now)));
    end else begin
      tick_beats++;
      fired = 0;
      while (q_count > 0 && fired < MAX_FIRES) begin
        head = q_order[0];
        if (q_deadline[head] > now) break;
        unlink_slot(0);
        batch.push_back(make_event(KIND_FIRE, head, q_deadline[head], '0));
        q_armed[head]    = 1'b0;
        q_deadline[head] = '0;
        fired++;
      end
      if (q_count > 0)
        batch.push_back(make_event(KIND_RELOAD, '0, '0,
                                   countdown_for(q_deadline[q_order[0]], now)));
    end
    if (batch.size() > 0) begin
      ev = batch.pop_back();
      ev.last = 1'b1;
      batch.push_back(ev);
      foreach (batch[k]) pending_events.push_back(batch[k]);
    end
  endfunction

  function automatic void check_event(result_t got);
    result_t want;
    if (pending_events.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ERROR: unexpected beat kind=%0d id=%0d at=%0d reload=%0d last=%0d",
                 $time, got.kind, got.fired_id, got.expired_at, got.reload, got.last);
      return;
    end
    want = pending_events.pop_front();
    if (got.kind !== want.kind || got.fired_id !== want.fired_id ||
        got.expired_at !== want.expired_at || got.reload !== want.reload ||
        got.last !== want.last) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display({"%0t ERROR: expected kind=%0d id=%0d at=%0d reload=%0d last=%0d,",
                  " got kind=%0d id=%0d at=%0d reload=%0d last=%0d"}, $time,
                 want.kind, want.fired_id, want.expired_at, want.reload, want.last,
                 got.kind, got.fired_id, got.expired_at, got.reload, got.last);
    end
    if (got.kind == KIND_FIRE) fire_seen++;
    else reload_seen++;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: all sampling happens at the rising edge, before any NBA lands, so
  // both channels are seen with their pre-edge values. The watchdog counts
  // cycles in which neither channel moves a beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (out_if.valid && out_if.ready)
        check_event({out_if.kind, out_if.fired_id, out_if.expired_at, out_if.reload,
                     out_if.last});
      if (in_if.valid && in_if.ready)
        predict_timer_events(in_if.action, in_if.timer_id, in_if.deadline, in_if.now);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_events.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request. The
  // hold-off is counted here so the sender keeps pushing beats meanwhile.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [TIME_W-1:0] random_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // Deadline around sim_now: already due, a few us out, in reload range, or beyond it.
  function automatic logic [TIME_W-1:0] near_deadline();
    case ($urandom_range(3))
      0:       return sim_now - TIME_W'($urandom_range(50));
      1:       return sim_now + TIME_W'($urandom_range(20));
      2:       return sim_now + TIME_W'($urandom_range(70000));
      default: return sim_now + TIME_W'($urandom_range(200000));
    endcase
  endfunction

  // Offer one beat and hold it until accepted; an idle gap may come first.
  task automatic send_beat(logic act, logic [ID_W-1:0] id, logic [TIME_W-1:0] dl,
                           logic [TIME_W-1:0] now);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.timer_id <= id;
    in_if.deadline <= dl;
    in_if.now      <= now;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic arm_timer(int id, logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now);
    send_beat(ACT_ARM, ID_W'(id), dl, now);
  endtask

  // id and deadline are don't-care on a tick, so they carry noise
  task automatic tick_at(logic [TIME_W-1:0] now);
    send_beat(ACT_TICK, ID_W'($urandom), random_time(), now);
  endtask

  // Sender pause: drop valid, let the monitor log the last beat, then wait for results.
  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    tick_at('0);                          // empty queue: no beat at all
    tick_at(TIME_MAX);
    arm_timer(0, TIME_MAX, '0);           // head, far ahead: saturates
    arm_timer(NTIMERS - 1, '0, TIME_MAX); // new head, long past: minimum reload
    arm_timer(3, '0, '0);                 // equal deadline goes behind: silent
    arm_timer(7, 63'd1000, 63'd998);      // mid-queue insert: silent
    arm_timer(NTIMERS - 1, 63'd10, '0);   // re-arm moves it behind timer 3
    tick_at(63'd0);                       // due exactly now: fires 3, reload 10
    tick_at(63'd9);                       // nothing due, one us left clamps up
    arm_timer(9, 63'd1000, '0);           // ties with 7, queued after it
    tick_at(63'd1000);                    // fires 15, 7, 9 in order; head 0 saturates
    arm_timer(0, 63'd70000, 63'd4465);    // re-arm into empty queue, one past the ceiling
    arm_timer(1, 63'd65534, '0);          // ceiling exactly
    arm_timer(2, 63'd65533, '0);          // just under the ceiling
    arm_timer(4, 63'd20, 63'd18);         // floor exactly
    arm_timer(4, 63'd3, '0);              // re-arm of the head stays head
    tick_at(TIME_MAX);                    // flushes everything, no reload left
    wait_all_results();
  endtask

  // Full queue with many tied deadlines; the first tick fires all sixteen.
  task automatic test_full_queue();
    int k;
    no_idle = 1'b1;
    for (k = 0; k < NTIMERS; k++)
      arm_timer((k * 7 + 5) % NTIMERS, sim_now + TIME_W'($urandom_range(40)), sim_now);
    tick_at(sim_now + 63'd100);
    for (k = 0; k < NTIMERS; k++)
      arm_timer((k * 3 + 1) % NTIMERS, sim_now + TIME_W'($urandom_range(40)), sim_now);
    tick_at(sim_now + 63'd20);            // partial walk, head left behind
    wait_all_results();
    no_idle = 1'b0;
  endtask

  // Receiver holds off while each arm lands at the head, so results back up
  // into the block and the input stalls; then the sender waits for the drain.
  task automatic test_backpressure();
    int k;
    sim_now += 63'd1000;
    tick_at(sim_now);                     // clear whatever the previous test left
    wait_all_results();
    hold_request = 1'b1;
    for (k = 0; k < 8; k++)
      arm_timer(k, sim_now + TIME_W'(1000 - 100 * k), sim_now);
    tick_at(sim_now + 63'd5000);
    wait_all_results();
    sim_now += 63'd10000;
  endtask

  // Mostly well-formed: a few arms around the running time, then a tick further on.
  // The rest is ticks and arms with unrelated full-width times.
  task automatic test_random_traffic();
    int start_beats;
    int done;
    int pick;
    int n;
    int k;
    start_beats = beats_sent;
    done = 0;
    while (done < RANDOM_BEATS) begin
      no_idle = (done >= 60 && done < 100);   // one stretch with no idling
      pick = $urandom_range(99);
      if (pick < 70) begin
        n = $urandom_range(5, 1);
        for (k = 0; k < n; k++) arm_timer($urandom_range(NTIMERS - 1), near_deadline(), sim_now);
        sim_now += TIME_W'($urandom_range($urandom_range(1) ? 70000 : 100));
        tick_at(sim_now);
      end else if (pick < 85) begin
        tick_at(random_time());
      end else begin
        arm_timer($urandom_range(NTIMERS - 1), random_time(), random_time());
      end
      done = beats_sent - start_beats;
    end
    no_idle = 1'b0;
    wait_all_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    in_if.valid    <= 1'b0;
    in_if.action   <= ACT_ARM;
    in_if.timer_id <= '0;
    in_if.deadline <= '0;
    in_if.now      <= '0;
    sim_now = random_time() >> 24;       // ~39-bit base, far from wrap
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_queue();
    test_backpressure();
    test_random_traffic();

    // trailing window: anything arriving now is unexpected
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_events.size() != 0) begin
      errors++;
      $display("ERROR: %0d expected results never arrived", pending_events.size());
    end

    $display("Summary: %0d arm and %0d tick beats driven, %0d fire and %0d reload beats checked",
             arm_beats, tick_beats, fire_seen, reload_seen);
    $display("Summary: %0d errors", errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/sdtq_pkg.sv
design/sdtq_if.sv
design/sdtq_entry_ram.sv
design/sdtq_out_stage.sv
design/sdtq_seq.sv
design/sorted_deadline_timer_queue_top.sv
tb/tb.sv
